>>> src/fte_pkg.sv
// ----------------------------------------------------------------------------
// fte_pkg: shared types and constants
// Constants, command codes and status codes for the frame transform engine.
// ----------------------------------------------------------------------------
package fte_pkg;
  localparam int MaxSide   = 64;
  localparam int SideW     = $clog2(MaxSide);
  localparam int DimW      = SideW + 1;
  localparam int Depth     = MaxSide * MaxSide;
  localparam int AddrW     = $clog2(Depth);
  localparam int PixW      = 24;
  localparam logic [PixW-1:0] WhitePixel = {PixW{1'b1}};

  typedef enum logic [3:0] {
    FUNC_WRITE = 4'd0, FUNC_READ = 4'd1, FUNC_UP = 4'd2, FUNC_DOWN = 4'd3,
    FUNC_LEFT = 4'd4, FUNC_RIGHT = 4'd5, FUNC_ROT_ROW = 4'd6, FUNC_ROT_COL = 4'd7,
    FUNC_MIR_ROW = 4'd8, FUNC_MIR_COL = 4'd9
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0, ST_NOT_SQUARE = 2'd1, ST_BAD_ADDR = 2'd2
  } status_t;

  localparam logic [0:0] RegWidth  = 1'b0;
  localparam logic [0:0] RegHeight = 1'b1;

  typedef struct packed {
    logic [3:0]      func;
    logic [SideW-1:0] pixel_row;
    logic [SideW-1:0] pixel_column;
    logic [7:0]      red_in;
    logic [7:0]      green_in;
    logic [7:0]      blue_in;
    logic [6:0]      shift_amount;
  } cmd_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [1:0] status;
  } res_t;

  // source coordinate request from sequencer to address unit
  typedef struct packed {
    logic [3:0]       op;
    logic [SideW-1:0] r;
    logic [SideW-1:0] c;
    logic [DimW-1:0]  k;
    logic [DimW-1:0]  w;
    logic [DimW-1:0]  h;
  } areq_t;

  typedef struct packed {
    logic             white;
    logic [AddrW-1:0] addr;
  } aresp_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [6:0] v);
    logic [DimW-1:0] res;
    if (v == 7'd0) res = DimW'(1);
    else if (32'(v) > MaxSide) res = DimW'(MaxSide);
    else res = DimW'(v);
    return res;
  endfunction
endpackage

>>> src/fte_if.sv
// ----------------------------------------------------------------------------
// fte_cmd_if / fte_res_if: valid-ready channels
// Command channel and result channel of the frame transform engine.
// ----------------------------------------------------------------------------
interface fte_cmd_if;
  logic          valid;
  logic          ready;
  fte_pkg::cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fte_res_if;
  logic          valid;
  logic          ready;
  fte_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/fte_addr_unit.sv
// ----------------------------------------------------------------------------
// fte_addr_unit: shared source address unit
// Maps a destination pixel to its source entry, or flags a white fill.
// ----------------------------------------------------------------------------
module fte_addr_unit (
  input  fte_pkg::areq_t  req,
  output fte_pkg::aresp_t resp
);
  localparam int W = fte_pkg::DimW + 1;
  logic [W-1:0] r, c, k, w, h, sr, sc;
  logic         white;

  always_comb begin
    r = W'(req.r);
    c = W'(req.c);
    k = W'(req.k);
    w = W'(req.w);
    h = W'(req.h);
    sr = r;
    sc = c;
    white = 1'b0;
    unique case (req.op)
      fte_pkg::FUNC_UP: begin
        white = !(k < h - r);
        sr = r + k;
      end
      fte_pkg::FUNC_DOWN: begin
        white = r < k;
        sr = r - k;
      end
      fte_pkg::FUNC_LEFT: begin
        white = !(k < w - c);
        sc = c + k;
      end
      fte_pkg::FUNC_RIGHT: begin
        white = c < k;
        sc = c - k;
      end
      fte_pkg::FUNC_ROT_ROW: begin
        sr = c;
        sc = h - W'(1) - r;
      end
      fte_pkg::FUNC_ROT_COL: begin
        sr = w - W'(1) - c;
        sc = r;
      end
      fte_pkg::FUNC_MIR_ROW: sr = h - W'(1) - r;
      default: sc = w - W'(1) - c;
    endcase
  end

  // one multiply per pixel: row times stride plus column
  assign resp.white = white;
  assign resp.addr  = fte_pkg::AddrW'(32'(sr) * 32'(w) + 32'(sc));
endmodule

>>> src/fte_seq.sv
// ----------------------------------------------------------------------------
// fte_seq: command sequencer
// Runs pixel commands and sweeps the frame for transforms through a scratch
// store, then copies scratch back.
// ----------------------------------------------------------------------------
module fte_seq (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [6:0] cfg_data,
  fte_cmd_if.sink   cmd,
  fte_res_if.source res
);
  localparam int SW = fte_pkg::SideW;
  localparam int AW = fte_pkg::AddrW;
  localparam int DW = fte_pkg::DimW;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_XREAD, S_XWRITE, S_CREAD, S_CWRITE, S_RESULT
  } state_t;

  state_t state;
  logic [6:0] width_reg, height_reg;
  fte_pkg::cmd_t cur;
  logic [DW-1:0] w, h, k;
  logic [SW-1:0] r, c;
  logic [AW-1:0] dst;
  logic          fill_white;
  fte_pkg::res_t result;

  logic [fte_pkg::PixW-1:0] frame_mem [fte_pkg::Depth];
  logic [fte_pkg::PixW-1:0] scratch_mem [fte_pkg::Depth];
  logic [fte_pkg::PixW-1:0] frame_q, scratch_q;

  fte_pkg::areq_t  areq;
  fte_pkg::aresp_t aresp;

  fte_addr_unit u_addr (.req(areq), .resp(aresp));

  logic [DW-1:0] cw, ch;
  logic          bad_addr;
  logic [AW-1:0] pix_addr;
  logic          last_pix;
  fte_pkg::status_t acc_status;

  assign cw = fte_pkg::clamp_dim(width_reg);
  assign ch = fte_pkg::clamp_dim(height_reg);
  assign bad_addr = (DW'(cmd.data.pixel_row) >= ch) || (DW'(cmd.data.pixel_column) >= cw);
  assign pix_addr = AW'(32'(cmd.data.pixel_row) * 32'(cw) + 32'(cmd.data.pixel_column));
  assign last_pix = (DW'(r) == h - DW'(1)) && (DW'(c) == w - DW'(1));

  // status of the command on offer, known at its transfer
  always_comb begin
    acc_status = fte_pkg::ST_DONE;
    if ((cmd.data.func == fte_pkg::FUNC_WRITE || cmd.data.func == fte_pkg::FUNC_READ) &&
        bad_addr) begin
      acc_status = fte_pkg::ST_BAD_ADDR;
    end else if ((cmd.data.func == fte_pkg::FUNC_ROT_ROW ||
                  cmd.data.func == fte_pkg::FUNC_ROT_COL) && cw != ch) begin
      acc_status = fte_pkg::ST_NOT_SQUARE;
    end
  end

  always_comb begin
    areq.op = cur.func;
    areq.r  = r;
    areq.c  = c;
    areq.k  = (cur.shift_amount > 7'(fte_pkg::MaxSide)) ? DW'(fte_pkg::MaxSide) :
              DW'(cur.shift_amount);
    areq.w  = w;
    areq.h  = h;
  end

  assign cmd.ready = (state == S_IDLE);
  assign res.valid = (state == S_RESULT);
  assign res.data  = result;

  // frame memory: one read and one write port
  logic                     fwe, swe;
  logic [AW-1:0]            fwaddr, fraddr, swaddr;
  logic [fte_pkg::PixW-1:0] fwdata, swdata;

  always_comb begin
    fwe = 1'b0;
    fwaddr = dst;
    fwdata = scratch_q;
    fraddr = aresp.addr;
    swe = 1'b0;
    swaddr = dst;
    swdata = fill_white ? fte_pkg::WhitePixel : frame_q;
    if (state == S_IDLE) begin
      fraddr = pix_addr;
      fwaddr = pix_addr;
      fwdata = {cmd.data.blue_in, cmd.data.green_in, cmd.data.red_in};
      fwe = cmd.valid && (cmd.data.func == fte_pkg::FUNC_WRITE) && !bad_addr;
    end
    if (state == S_XWRITE) swe = 1'b1;
    if (state == S_CWRITE) fwe = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (fwe) frame_mem[fwaddr] <= fwdata;
    frame_q <= frame_mem[fraddr];
    if (swe) scratch_mem[swaddr] <= swdata;
    scratch_q <= scratch_mem[dst];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      width_reg <= 7'd64;
      height_reg <= 7'd64;
    end else begin
      if (cfg_we && cfg_index == fte_pkg::RegWidth) width_reg <= cfg_data;
      if (cfg_we && cfg_index == fte_pkg::RegHeight) height_reg <= cfg_data;
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            cur <= cmd.data;
            w <= cw;
            h <= ch;
            r <= '0;
            c <= '0;
            dst <= '0;
            result <= '{red_out: 8'd0, green_out: 8'd0, blue_out: 8'd0,
                        status: acc_status};
            state <= S_RESULT;
            unique case (cmd.data.func)
              fte_pkg::FUNC_WRITE, fte_pkg::FUNC_READ: begin
                if (!bad_addr && cmd.data.func == fte_pkg::FUNC_READ) state <= S_READ;
              end
              fte_pkg::FUNC_UP, fte_pkg::FUNC_DOWN,
              fte_pkg::FUNC_LEFT, fte_pkg::FUNC_RIGHT: begin
                if (cmd.data.shift_amount != 7'd0) state <= S_XREAD;
              end
              fte_pkg::FUNC_ROT_ROW, fte_pkg::FUNC_ROT_COL: begin
                if (cw == ch) state <= S_XREAD;
              end
              fte_pkg::FUNC_MIR_ROW, fte_pkg::FUNC_MIR_COL: state <= S_XREAD;
              default: ;
            endcase
          end
        end
        S_READ: begin
          result <= '{red_out: frame_q[7:0], green_out: frame_q[15:8],
                      blue_out: frame_q[23:16], status: fte_pkg::ST_DONE};
          state <= S_RESULT;
        end
        S_XREAD: begin
          fill_white <= aresp.white;
          state <= S_XWRITE;
        end
        S_XWRITE: begin
          if (last_pix) begin
            dst <= '0;
            state <= S_CREAD;
          end else begin
            dst <= dst + AW'(1);
            if (DW'(c) == w - DW'(1)) begin
              c <= '0;
              r <= r + SW'(1);
            end else c <= c + SW'(1);
            state <= S_XREAD;
          end
        end
        S_CREAD: state <= S_CWRITE;
        S_CWRITE: begin
          if (32'(dst) == 32'(w) * 32'(h) - 1) state <= S_RESULT;
          else begin
            dst <= dst + AW'(1);
            state <= S_CREAD;
          end
        end
        S_RESULT: if (res.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |=> res.valid && $stable(res.data))
    else $error("result changed while stalled");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |=> !cmd.ready)
    else $error("accepted while busy");
  a_nonsq: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.data.status == fte_pkg::ST_NOT_SQUARE |-> w != h)
    else $error("square frame flagged");
endmodule

>>> src/frame_transform_engine.sv
// ----------------------------------------------------------------------------
// frame_transform_engine: RGB frame store with shift, rotate and mirror
// Top level; holds the configuration port and the command sequencer.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  cmd      in   func, pixel_row, pixel_column, red/green/blue_in, shift_amount
//  res      out  red/green/blue_out, status
//  cfg      in   cfg_we, cfg_index, cfg_data (width, height)
//
// pixel write: result valid in the cycle after the command transfer; read: via S_READ
// transforms: S_XREAD then S_XWRITE per pixel into scratch, S_CREAD then S_CWRITE per
//   pixel copying back, paced by the registered read of each store
// one command at a time; ready low until the result transfer
// reset clears control and dimensions only; the store is undefined until written
module frame_transform_engine (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [6:0] cfg_data,
  fte_cmd_if.sink   cmd,
  fte_res_if.source res
);
  // sequencer owns the stores and the shared address unit
  fte_seq u_seq (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd), .res(res)
  );
endmodule

>>> verif/frame_transform_engine_test.sv
// ----------------------------------------------------------------------------
// frame_transform_engine_test: self-checking bench for the frame engine
// Runs a table of directed commands, then random command streams under
// several frame sizes and idle patterns. Every result transfer is checked
// against the table answer where one is given, else a software copy of the frame store.
// ----------------------------------------------------------------------------
module frame_transform_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 2_000_000;
  localparam int RandPerPhase = 17;
  // a command code with no meaning; the engine must answer done and do nothing
  localparam logic [3:0] FuncUndefined = 4'd12;

  typedef struct {
    bit                    is_cfg;
    logic                  cfg_idx;
    logic [6:0]            cfg_val;
    fte_pkg::cmd_t         cmd;
    bit                    typed;
    fte_pkg::res_t         want;
  } step_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic [6:0] cfg_data;

  fte_cmd_if cmd_ch ();
  fte_res_if res_ch ();

  frame_transform_engine dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd_ch),
    .res       (res_ch)
  );

  // shadow frame store: pixel value plus a flag telling whether it was ever written
  logic [23:0] frame_pix [fte_pkg::Depth];
  bit          frame_known [fte_pkg::Depth];
  logic [23:0] spare_pix [fte_pkg::Depth];
  bit          spare_known [fte_pkg::Depth];
  logic [6:0]  width_reg;
  logic [6:0]  height_reg;

  fte_pkg::res_t pending_results[$];
  int   errors;
  int   cycles;

  // idle control
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_left;

  // typed expectation handed from the driver to the monitor at acceptance
  bit            next_typed;
  fte_pkg::res_t next_want;

  step_t directed[$];

  // ---------------------------------------------------------------------------
  // frame model
  // ---------------------------------------------------------------------------
  function automatic int eff_dim(logic [6:0] v);
    if (v == 0) return 1;
    if (v > fte_pkg::MaxSide) return fte_pkg::MaxSide;
    return int'(v);
  endfunction

  // rebuilds the whole w x h frame for shift, rotate and mirror commands
  function automatic void remap_frame(logic [3:0] op, int k, int w, int h);
    int src;
    bit white;
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        white = 1'b0;
        src = 0;
        case (op)
          fte_pkg::FUNC_UP: begin
            if (k < h - r) src = (r + k) * w + c; else white = 1'b1;
          end
          fte_pkg::FUNC_DOWN: begin
            if (r >= k) src = (r - k) * w + c; else white = 1'b1;
          end
          fte_pkg::FUNC_LEFT: begin
            if (k < w - c) src = r * w + c + k; else white = 1'b1;
          end
          fte_pkg::FUNC_RIGHT: begin
            if (c >= k) src = r * w + c - k; else white = 1'b1;
          end
          fte_pkg::FUNC_ROT_ROW: src = c * w + (h - 1 - r);
          fte_pkg::FUNC_ROT_COL: src = (w - 1 - c) * w + r;
          fte_pkg::FUNC_MIR_ROW: src = (h - 1 - r) * w + c;
          default:               src = r * w + (w - 1 - c);
        endcase
        spare_pix[r * w + c]   = white ? fte_pkg::WhitePixel : frame_pix[src];
        spare_known[r * w + c] = white ? 1'b1 : frame_known[src];
      end
    end
    for (int i = 0; i < w * h; i++) begin
      frame_pix[i]   = spare_pix[i];
      frame_known[i] = spare_known[i];
    end
  endfunction

  // applies one accepted command to the shadow store and returns its answer
  function automatic fte_pkg::res_t apply_command(fte_pkg::cmd_t c);
    fte_pkg::res_t o;
    int w;
    int h;
    int idx;
    w = eff_dim(width_reg);
    h = eff_dim(height_reg);
    o = '0;
    o.status = fte_pkg::ST_DONE;
    idx = int'(c.pixel_row) * w + int'(c.pixel_column);
    case (c.func)
      fte_pkg::FUNC_WRITE, fte_pkg::FUNC_READ: begin
        if (int'(c.pixel_row) >= h || int'(c.pixel_column) >= w) begin
          o.status = fte_pkg::ST_BAD_ADDR;
        end else if (c.func == fte_pkg::FUNC_WRITE) begin
          frame_pix[idx]   = {c.blue_in, c.green_in, c.red_in};
          frame_known[idx] = 1'b1;
        end else begin
          o.red_out   = frame_pix[idx][7:0];
          o.green_out = frame_pix[idx][15:8];
          o.blue_out  = frame_pix[idx][23:16];
        end
      end
      fte_pkg::FUNC_UP, fte_pkg::FUNC_DOWN, fte_pkg::FUNC_LEFT, fte_pkg::FUNC_RIGHT: begin
        if (c.shift_amount != 0) remap_frame(c.func, int'(c.shift_amount), w, h);
      end
      fte_pkg::FUNC_ROT_ROW, fte_pkg::FUNC_ROT_COL: begin
        if (w != h) o.status = fte_pkg::ST_NOT_SQUARE;
        else remap_frame(c.func, 0, w, h);
      end
      fte_pkg::FUNC_MIR_ROW, fte_pkg::FUNC_MIR_COL: remap_frame(c.func, 0, w, h);
      default: ;
    endcase
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // table helpers
  // ---------------------------------------------------------------------------
  function automatic step_t op(logic [3:0] f, int r, int c, logic [23:0] p, int k);
    step_t s;
    s = '{default: '0};
    s.cmd.func = f;
    s.cmd.pixel_row = fte_pkg::SideW'(r);
    s.cmd.pixel_column = fte_pkg::SideW'(c);
    s.cmd.red_in = p[7:0];
    s.cmd.green_in = p[15:8];
    s.cmd.blue_in = p[23:16];
    s.cmd.shift_amount = 7'(k);
    return s;
  endfunction

  function automatic step_t chk(step_t s, logic [23:0] p, fte_pkg::status_t st);
    s.typed = 1'b1;
    s.want = '{red_out: p[7:0], green_out: p[15:8], blue_out: p[23:16], status: st};
    return s;
  endfunction

  function automatic step_t cfg(logic i, int v);
    step_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1;
    s.cfg_idx = i;
    s.cfg_val = 7'(v);
    return s;
  endfunction

  // random command, mostly aimed inside the frame; never reads a pixel never written
  function automatic fte_pkg::cmd_t rand_command();
    fte_pkg::cmd_t c;
    int w;
    int h;
    int pick;
    w = eff_dim(width_reg);
    h = eff_dim(height_reg);
    pick = $urandom_range(99);
    c.func = (pick < 30) ? fte_pkg::FUNC_WRITE : (pick < 55) ? fte_pkg::FUNC_READ :
             (pick < 92) ? 4'($urandom_range(9, 2)) : 4'($urandom_range(15, 10));
    c.pixel_row = ($urandom_range(99) < 85) ? fte_pkg::SideW'($urandom_range(h - 1))
                                            : fte_pkg::SideW'($urandom_range(63));
    c.pixel_column = ($urandom_range(99) < 85) ? fte_pkg::SideW'($urandom_range(w - 1))
                                               : fte_pkg::SideW'($urandom_range(63));
    c.red_in = 8'($urandom);
    c.green_in = 8'($urandom);
    c.blue_in = 8'($urandom);
    c.shift_amount = ($urandom_range(99) < 75) ? 7'($urandom_range(w > h ? w : h))
                                               : 7'($urandom_range(127));
    if (c.func == fte_pkg::FUNC_READ && int'(c.pixel_row) < h &&
        int'(c.pixel_column) < w &&
        !frame_known[int'(c.pixel_row) * w + int'(c.pixel_column)]) begin
      c.func = fte_pkg::FUNC_WRITE;
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // clock, timeout
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t timeout with %0d results outstanding", $time, pending_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on command transfer, checks on result transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    fte_pkg::res_t got;
    fte_pkg::res_t exp_r;
    fte_pkg::res_t pred;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = res_ch.data;
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result transfer %h", $time, got);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (got.red_out !== exp_r.red_out) begin
          $display("%0t red_out exp %h got %h", $time, exp_r.red_out, got.red_out);
          errors++;
        end
        if (got.green_out !== exp_r.green_out) begin
          $display("%0t green_out exp %h got %h", $time, exp_r.green_out, got.green_out);
          errors++;
        end
        if (got.blue_out !== exp_r.blue_out) begin
          $display("%0t blue_out exp %h got %h", $time, exp_r.blue_out, got.blue_out);
          errors++;
        end
        if (got.status !== exp_r.status) begin
          $display("%0t status exp %0d got %0d", $time, exp_r.status, got.status);
          errors++;
        end
      end
    end
    if (!rst && cmd_ch.valid && cmd_ch.ready) begin
      // the shadow store is updated even when the answer is typed in the table
      pred = apply_command(cmd_ch.data);
      pending_results.push_back(next_typed ? next_want : pred);
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        hold_off_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // driver tasks; all called and returning at a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_command(fte_pkg::cmd_t c, bit typed, fte_pkg::res_t want);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    next_typed = typed;
    next_want = want;
    cmd_ch.valid <= 1'b1;
    cmd_ch.data <= c;
    do @(posedge clk); while (!(cmd_ch.valid && cmd_ch.ready));
    @(negedge clk);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    // let the last result transfer settle before touching the registers
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic i, logic [6:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= i;
    cfg_data <= v;
    if (i == fte_pkg::RegWidth) width_reg = v; else height_reg = v;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int dims [4][2];
    int idle [4][2];
    fte_pkg::cmd_t c;
    step_t s;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.data = '0;
    errors = 0;
    cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_left = 0;
    next_typed = 1'b0;
    next_want = '0;
    width_reg = 7'd64;
    height_reg = 7'd64;
    for (int i = 0; i < fte_pkg::Depth; i++) begin
      frame_pix[i] = '0;
      frame_known[i] = 1'b0;
    end

    // directed table: full 64x64 frame first, then tiny and degenerate sizes
    directed.push_back(chk(op(fte_pkg::FUNC_WRITE, 0, 0, 24'h8000FF, 0), 24'h0,
                           fte_pkg::ST_DONE));
    directed.push_back(chk(op(fte_pkg::FUNC_READ, 0, 0, 24'h0, 0), 24'h8000FF,
                           fte_pkg::ST_DONE));
    directed.push_back(chk(op(fte_pkg::FUNC_WRITE, 63, 63, 24'hFFFFFF, 0), 24'h0,
                           fte_pkg::ST_DONE));
    directed.push_back(chk(op(fte_pkg::FUNC_READ, 63, 63, 24'h0, 0), 24'hFFFFFF,
                           fte_pkg::ST_DONE));
    // shift by zero leaves the frame alone
    directed.push_back(chk(op(fte_pkg::FUNC_RIGHT, 0, 0, 24'h0, 0), 24'h0,
                           fte_pkg::ST_DONE));
    directed.push_back(op(fte_pkg::FUNC_MIR_COL, 0, 0, 24'h0, 0));
    directed.push_back(op(fte_pkg::FUNC_READ, 0, 63, 24'h0, 0));
    directed.push_back(cfg(fte_pkg::RegWidth, 3));
    directed.push_back(cfg(fte_pkg::RegHeight, 2));
    // shift beyond the width whitens everything
    directed.push_back(chk(op(fte_pkg::FUNC_LEFT, 0, 0, 24'h0, 64), 24'h0,
                           fte_pkg::ST_DONE));
    directed.push_back(chk(op(fte_pkg::FUNC_READ, 1, 2, 24'h0, 0), 24'hFFFFFF,
                           fte_pkg::ST_DONE));
    directed.push_back(chk(op(fte_pkg::FUNC_WRITE, 2, 0, 24'h123456, 0), 24'h0,
                           fte_pkg::ST_BAD_ADDR));
    directed.push_back(chk(op(fte_pkg::FUNC_READ, 0, 3, 24'h0, 0), 24'h0,
                           fte_pkg::ST_BAD_ADDR));
    directed.push_back(chk(op(fte_pkg::FUNC_ROT_ROW, 0, 0, 24'h0, 0), 24'h0,
                           fte_pkg::ST_NOT_SQUARE));
    directed.push_back(op(fte_pkg::FUNC_WRITE, 0, 0, 24'h030201, 0));
    directed.push_back(op(fte_pkg::FUNC_WRITE, 1, 2, 24'hA5A55A, 0));
    directed.push_back(op(fte_pkg::FUNC_UP, 0, 0, 24'h0, 1));
    directed.push_back(op(fte_pkg::FUNC_DOWN, 0, 0, 24'h0, 1));
    directed.push_back(op(fte_pkg::FUNC_RIGHT, 0, 0, 24'h0, 2));
    directed.push_back(op(fte_pkg::FUNC_MIR_ROW, 0, 0, 24'h0, 0));
    directed.push_back(op(fte_pkg::FUNC_READ, 1, 2, 24'h0, 0));
    directed.push_back(chk(op(FuncUndefined, 5, 5, 24'h0, 0), 24'h0, fte_pkg::ST_DONE));
    // zero width acts as one, oversized height as the maximum
    directed.push_back(cfg(fte_pkg::RegWidth, 0));
    directed.push_back(cfg(fte_pkg::RegHeight, 127));
    directed.push_back(chk(op(fte_pkg::FUNC_ROT_COL, 0, 0, 24'h0, 0), 24'h0,
                           fte_pkg::ST_NOT_SQUARE));
    directed.push_back(chk(op(fte_pkg::FUNC_DOWN, 0, 0, 24'h0, 127), 24'h0,
                           fte_pkg::ST_DONE));
    directed.push_back(chk(op(fte_pkg::FUNC_READ, 63, 0, 24'h0, 0), 24'hFFFFFF,
                           fte_pkg::ST_DONE));
    directed.push_back(cfg(fte_pkg::RegWidth, 2));
    directed.push_back(cfg(fte_pkg::RegHeight, 2));
    directed.push_back(op(fte_pkg::FUNC_LEFT, 0, 0, 24'h0, 64));
    directed.push_back(op(fte_pkg::FUNC_WRITE, 0, 1, 24'h00FF00, 0));
    directed.push_back(op(fte_pkg::FUNC_ROT_ROW, 0, 0, 24'h0, 0));
    directed.push_back(op(fte_pkg::FUNC_ROT_COL, 0, 0, 24'h0, 0));
    directed.push_back(op(fte_pkg::FUNC_READ, 1, 0, 24'h0, 0));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    foreach (directed[i]) begin
      if (directed[i].is_cfg) write_reg(directed[i].cfg_idx, directed[i].cfg_val);
      else send_command(directed[i].cmd, directed[i].typed, directed[i].want);
    end

    // random phases: frame size and idle pattern per phase
    dims = '{'{5, 5}, '{7, 3}, '{1, 1}, '{64, 2}};
    idle = '{'{0, 0}, '{51, 0}, '{0, 51}, '{38, 38}};
    for (int p = 0; p < 4; p++) begin
      write_reg(fte_pkg::RegWidth, 7'(dims[p][0]));
      write_reg(fte_pkg::RegHeight, 7'(dims[p][1]));
      send_idle_pct = idle[p][0];
      recv_stall_pct = idle[p][1];
      // whiten the frame so every pixel in use has a known value
      s = op(fte_pkg::FUNC_UP, 0, 0, 24'h0, 64);
      send_command(s.cmd, 1'b0, '0);
      // long receiver hold-off while commands keep coming; input must back up
      if (p == 0) hold_off_left = 300;
      for (int n = 0; n < RandPerPhase; n++) begin
        c = rand_command();
        send_command(c, 1'b0, '0);
      end
    end

    drain();
    // catch any stray result after the last one expected
    repeat (50) @(negedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

>>> filelist.f
src/fte_pkg.sv
src/fte_if.sv
src/fte_addr_unit.sv
src/fte_seq.sv
src/frame_transform_engine.sv
verif/frame_transform_engine_test.sv
